// ----- hw/rtl/tlms_pkg.sv -----
// ----------------------------------------------------------------------------
// tlms_pkg
// Shared types and constants of the traffic light mode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlms_pkg;

  localparam int NORMAL_STEPS = 5;
  localparam int NIGHT_STEPS  = 2;

  localparam int LAMP_W       = 3;
  localparam int MODE_W       = 2;
  localparam int EVENT_W      = 2;
  localparam int TIMER_W      = 16;
  localparam int NORMAL_PAT_W = LAMP_W * NORMAL_STEPS;
  localparam int NIGHT_PAT_W  = LAMP_W * NIGHT_STEPS;
  localparam int NORMAL_STEP_W = $clog2(NORMAL_STEPS);
  localparam int NIGHT_STEP_W  = $clog2(NIGHT_STEPS);

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_PERIOD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLINK_PERIOD  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_PAT    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NIGHT_PAT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_EMERG_PAT     = 3'd4;

  // register reset values
  localparam logic [TIMER_W-1:0]      NORMAL_PERIOD_RST = 16'd1000;
  localparam logic [TIMER_W-1:0]      BLINK_PERIOD_RST  = 16'd500;
  localparam logic [NORMAL_PAT_W-1:0] NORMAL_PAT_RST    = 15'd15243;
  localparam logic [NIGHT_PAT_W-1:0]  NIGHT_PAT_RST     = 6'd47;
  localparam logic [LAMP_W-1:0]       EMERG_PAT_RST     = 3'd3;

  // modes
  localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NIGHT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EMERGENCY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

  // decoded button events
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

  typedef struct packed {
    logic [TIMER_W-1:0]      normal_period;
    logic [TIMER_W-1:0]      blink_period;
    logic [NORMAL_PAT_W-1:0] normal_pat;
    logic [NIGHT_PAT_W-1:0]  night_pat;
    logic [LAMP_W-1:0]       emerg_pat;
  } tlms_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LAMP_W-1:0] lamps;
  } tlms_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tlms_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tlms_cfg_regs
// Configuration register file: periods and lamp pattern banks.
// ----------------------------------------------------------------------------
`default_nettype none

module tlms_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [tlms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [tlms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tlms_pkg::tlms_cfg_t                  cfg
);
  import tlms_pkg::*;

  tlms_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_period <= NORMAL_PERIOD_RST;
      cfg_r.blink_period  <= BLINK_PERIOD_RST;
      cfg_r.normal_pat    <= NORMAL_PAT_RST;
      cfg_r.night_pat     <= NIGHT_PAT_RST;
      cfg_r.emerg_pat     <= EMERG_PAT_RST;
    end else if (cfg_we) begin
      // indexes past the last register are dropped
      unique case (cfg_addr)
        REG_NORMAL_PERIOD: cfg_r.normal_period <= cfg_wdata[TIMER_W-1:0];
        REG_BLINK_PERIOD:  cfg_r.blink_period  <= cfg_wdata[TIMER_W-1:0];
        REG_NORMAL_PAT:    cfg_r.normal_pat    <= cfg_wdata[NORMAL_PAT_W-1:0];
        REG_NIGHT_PAT:     cfg_r.night_pat     <= cfg_wdata[NIGHT_PAT_W-1:0];
        REG_EMERG_PAT:     cfg_r.emerg_pat     <= cfg_wdata[LAMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tlms_core.sv -----
// ----------------------------------------------------------------------------
// tlms_core
// Mode, timer and step registers with the per-tick next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tlms_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tlms_pkg::tlms_cfg_t          cfg,
  input  wire logic                         tick_acc,
  input  wire logic [tlms_pkg::EVENT_W-1:0] press_code,
  output tlms_pkg::tlms_res_t               res
);
  import tlms_pkg::*;

  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic [TIMER_W-1:0]       timer_r, timer_nxt, timer_dec;
  logic [NORMAL_STEP_W-1:0] nstep_r, nstep_nxt, nstep_adv;
  logic [NIGHT_STEP_W-1:0]  kstep_r, kstep_nxt, kstep_adv;
  logic [NORMAL_PAT_W-1:0]  normal_sh;
  logic [NIGHT_PAT_W-1:0]   night_sh;
  logic [LAMP_W-1:0]        lamps;

  assign timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;

  assign nstep_adv = (32'(nstep_r) + 1 >= NORMAL_STEPS) ? '0 : nstep_r + 1'b1;
  assign kstep_adv = (32'(kstep_r) + 1 >= NIGHT_STEPS)  ? '0 : kstep_r + 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    timer_nxt = timer_dec;
    nstep_nxt = nstep_r;
    kstep_nxt = kstep_r;
    unique case (mode_r)
      MODE_NORMAL: begin
        priority if (press_code == EV_SINGLE) begin
          mode_nxt  = MODE_NIGHT;
          timer_nxt = cfg.blink_period;
        end else if (press_code == EV_DOUBLE) begin
          mode_nxt  = MODE_EMERGENCY;
        end else if (timer_dec == '0) begin
          nstep_nxt = nstep_adv;
          timer_nxt = cfg.normal_period;
        end
      end
      MODE_NIGHT: begin
        priority if (press_code == EV_DOUBLE) begin
          mode_nxt  = MODE_EMERGENCY;
        end else if (press_code == EV_LONG) begin
          mode_nxt  = MODE_NORMAL;
          timer_nxt = cfg.normal_period;
        end else if (timer_dec == '0) begin
          kstep_nxt = kstep_adv;
          timer_nxt = cfg.blink_period;
        end
      end
      MODE_EMERGENCY: begin
        if (press_code == EV_SINGLE) begin
          mode_nxt  = MODE_NIGHT;
          timer_nxt = cfg.blink_period;
        end else if (press_code == EV_LONG) begin
          mode_nxt  = MODE_NORMAL;
          timer_nxt = cfg.normal_period;
        end
      end
      default: ;
    endcase
  end

  // pattern of the mode held at the start of the tick, step after the update;
  // a step past the bank reads as zero
  assign normal_sh = cfg.normal_pat >> (LAMP_W * 32'(nstep_nxt));
  assign night_sh  = cfg.night_pat  >> (LAMP_W * 32'(kstep_nxt));

  always_comb begin
    unique case (mode_r)
      MODE_NORMAL:    lamps = normal_sh[LAMP_W-1:0];
      MODE_NIGHT:     lamps = night_sh[LAMP_W-1:0];
      MODE_EMERGENCY: lamps = cfg.emerg_pat;
      default:        lamps = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      timer_r <= NORMAL_PERIOD_RST;
      nstep_r <= '0;
      kstep_r <= '0;
    end else if (tick_acc) begin
      mode_r  <= mode_nxt;
      timer_r <= timer_nxt;
      nstep_r <= nstep_nxt;
      kstep_r <= kstep_nxt;
    end
  end

  assign res.mode  = mode_nxt;
  assign res.lamps = lamps;

  a_mode_reachable: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_UNUSED)
    else $error("mode register holds the unused code");

  a_nstep_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nstep_r) < NORMAL_STEPS)
    else $error("normal step index out of range");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_acc |=> $stable(mode_r) && $stable(timer_r) && $stable(nstep_r))
    else $error("state changed without a tick");

  a_single_to_night: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc && mode_r == MODE_NORMAL && press_code == EV_SINGLE
      |=> mode_r == MODE_NIGHT && timer_r == $past(cfg.blink_period))
    else $error("single press in normal mode did not enter night mode");

endmodule

`default_nettype wire

// ----- hw/rtl/traffic_light_mode_sequencer.sv -----
// ----------------------------------------------------------------------------
// traffic_light_mode_sequencer
// Lamp sequencer with normal, night blink and emergency modes.
// ----------------------------------------------------------------------------
// Each request on the in_ stream is one system tick carrying a decoded
// button event; each tick gives exactly one request on the out_ stream with
// the lamp pattern to drive and the mode after the tick.
// Timing: the result of an accepted tick is taken into the output register at
// the edge that accepts it. One tick a cycle is sustained while the receiver
// does not stall, the mode/timer/step update being a single pass of logic.
// Stalls: in_tready stays high while the output register is empty or being
// drained, so a stalled receiver stops the input after one held result.
// Reset (rst_n low, synchronous) puts the block in normal mode at step 0 with
// the timer at 1000 ticks, restores the register reset values and empties the
// output register.
// Configuration: write cfg_wdata to register cfg_addr with cfg_we high, only
// while no tick is in flight; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_mode_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [tlms_pkg::IN_TDATA_W-1:0]  in_tdata,   // [1:0] press code
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [tlms_pkg::OUT_TDATA_W-1:0] out_tdata,  // [2:0] lamps, [4:3] mode
  input  wire logic                             cfg_we,
  input  wire logic [tlms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [tlms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tlms_pkg::*;

  tlms_cfg_t cfg;
  tlms_res_t res;
  tlms_res_t res_r;
  logic      out_valid_r;
  logic      tick_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign tick_acc  = in_tvalid && in_tready;

  tlms_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tlms_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tick_acc   (tick_acc),
    .press_code (in_tdata[EVENT_W-1:0]),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - LAMP_W - MODE_W){1'b0}}, res_r.mode, res_r.lamps};

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> out_valid_r)
    else $error("accepted tick left no result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !tick_acc)
    else $error("tick accepted over a held result");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.mode != MODE_UNUSED)
    else $error("result carries the unused mode code");

endmodule

`default_nettype wire

// ----- test/traffic_light_mode_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// traffic_light_mode_sequencer_tb
// Self-checking bench for the lamp sequencer: ticks with random button
// events go in under random source gaps and sink stalls. A scoreboard keeps
// its own copy of mode, timer and step indexes and checks every lamp/mode
// result in order. Register settings change between phases, once the block
// is idle. The settings include zero and full-scale periods, all-zero and
// all-one patterns, and writes to indexes past the last register.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_mode_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlms_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 230;
  localparam int FULL_PHASE_TICKS = 60;

  // every mode change, plus presses that each mode ignores
  localparam logic [EVENT_W-1:0] OPENING [16] = '{
    EV_NONE, EV_NONE, EV_LONG, EV_SINGLE, EV_SINGLE, EV_NONE, EV_DOUBLE, EV_DOUBLE,
    EV_NONE, EV_SINGLE, EV_LONG, EV_DOUBLE, EV_LONG, EV_NONE, EV_SINGLE, EV_LONG
  };

  // --------------------------------------------------------------------------
  // lamp predictor and result store
  // --------------------------------------------------------------------------
  class lamp_scoreboard;
    tlms_cfg_t          regs;
    logic [MODE_W-1:0]  mode;
    logic [TIMER_W-1:0] timer;
    int unsigned        normal_step;
    int unsigned        night_step;
    tlms_res_t          lamps_q[$];
    int                 fails;

    function new();
      regs.normal_period = NORMAL_PERIOD_RST;
      regs.blink_period  = BLINK_PERIOD_RST;
      regs.normal_pat    = NORMAL_PAT_RST;
      regs.night_pat     = NIGHT_PAT_RST;
      regs.emerg_pat     = EMERG_PAT_RST;
      mode        = MODE_NORMAL;
      timer       = NORMAL_PERIOD_RST;
      normal_step = 0;
      night_step  = 0;
      fails       = 0;
    endfunction

    task flag_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      fails++;
    endtask

    function int pending();
      return lamps_q.size();
    endfunction

    function void load_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_NORMAL_PERIOD: regs.normal_period = val;
        REG_BLINK_PERIOD:  regs.blink_period  = val;
        REG_NORMAL_PAT:    regs.normal_pat    = val[NORMAL_PAT_W-1:0];
        REG_NIGHT_PAT:     regs.night_pat     = val[NIGHT_PAT_W-1:0];
        REG_EMERG_PAT:     regs.emerg_pat     = val[LAMP_W-1:0];
        default: ;
      endcase
    endfunction

    // steps pointing past the bank read as dark
    function logic [LAMP_W-1:0] pick_lamps(logic [31:0] bank, int bank_w, int unsigned step);
      logic [31:0] shifted;
      if (LAMP_W * step >= bank_w) return '0;
      shifted = bank >> (LAMP_W * step);
      return shifted[LAMP_W-1:0];
    endfunction

    function int unsigned next_step(int unsigned step, int unsigned count);
      return (step + 1 >= count) ? 0 : step + 1;
    endfunction

    function void note_request(logic [EVENT_W-1:0] ev);
      tlms_res_t res;
      res.lamps = '0;
      if (timer > 0) timer--;
      // lamps follow the mode held at the start of the tick
      case (mode)
        MODE_NORMAL: begin
          if (ev == EV_SINGLE) begin
            mode  = MODE_NIGHT;
            timer = regs.blink_period;
          end else if (ev == EV_DOUBLE) begin
            mode = MODE_EMERGENCY;
          end else if (timer == 0) begin
            normal_step = next_step(normal_step, NORMAL_STEPS);
            timer       = regs.normal_period;
          end
          res.lamps = pick_lamps(regs.normal_pat, NORMAL_PAT_W, normal_step);
        end
        MODE_NIGHT: begin
          if (ev == EV_DOUBLE) begin
            mode = MODE_EMERGENCY;
          end else if (ev == EV_LONG) begin
            mode  = MODE_NORMAL;
            timer = regs.normal_period;
          end else if (timer == 0) begin
            night_step = next_step(night_step, NIGHT_STEPS);
            timer      = regs.blink_period;
          end
          res.lamps = pick_lamps(regs.night_pat, NIGHT_PAT_W, night_step);
        end
        MODE_EMERGENCY: begin
          // no timer reload on entry to emergency
          if (ev == EV_SINGLE) begin
            mode  = MODE_NIGHT;
            timer = regs.blink_period;
          end else if (ev == EV_LONG) begin
            mode  = MODE_NORMAL;
            timer = regs.normal_period;
          end
          res.lamps = regs.emerg_pat;
        end
        default: ;
      endcase
      res.mode = mode;
      lamps_q.push_back(res);
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] data);
      tlms_res_t exp_res;
      if (lamps_q.size() == 0) begin
        flag_mismatch($sformatf("result 0x%02h with nothing outstanding", data));
        return;
      end
      exp_res = lamps_q.pop_front();
      if (data[LAMP_W-1:0] !== exp_res.lamps)
        flag_mismatch($sformatf("lamps %0d, predicted %0d", data[LAMP_W-1:0], exp_res.lamps));
      if (data[LAMP_W+MODE_W-1:LAMP_W] !== exp_res.mode)
        flag_mismatch($sformatf("mode %0d, predicted %0d",
                                data[LAMP_W+MODE_W-1:LAMP_W], exp_res.mode));
      if (data[OUT_TDATA_W-1:LAMP_W+MODE_W] !== '0)
        flag_mismatch($sformatf("padding bits set in 0x%02h", data));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block and stimulus signals
  // --------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;   // [1:0] press code
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [2:0] lamps, [4:3] mode
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  lamp_scoreboard sb = new();

  bit src_steady;
  int src_run;
  int idle_cycles;

  traffic_light_mode_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // both handshakes are noted at the edge that completes them
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata[EVENT_W-1:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result sink: random stall before each request, with steady stretches
  initial begin : sink
    int stall;
    int run;
    bit steady;
    steady = 1'b0;
    run    = 0;
    @(posedge clk);
    forever begin
      if (run == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        run    = $urandom_range(20, 80);
      end
      run--;
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_tick(input logic [EVENT_W-1:0] ev);
    int gap;
    if (src_run == 0) begin
      src_steady = ($urandom_range(0, 3) == 0);
      src_run    = $urandom_range(20, 80);
    end
    src_run--;
    gap = src_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-EVENT_W){1'b0}}, ev};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the source off until every predicted result has been taken;
  // it first waits for the clock so the last accepted request is already noted
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.load_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] normal_period,
                              input logic [CFG_DATA_W-1:0] blink_period,
                              input logic [CFG_DATA_W-1:0] normal_pat,
                              input logic [CFG_DATA_W-1:0] night_pat,
                              input logic [CFG_DATA_W-1:0] emerg_pat);
    put_reg(REG_NORMAL_PERIOD, normal_period);
    put_reg(REG_BLINK_PERIOD, blink_period);
    put_reg(REG_NORMAL_PAT, normal_pat);
    put_reg(REG_NIGHT_PAT, night_pat);
    put_reg(REG_EMERG_PAT, emerg_pat);
    // indexes past the last register must leave everything alone
    put_reg(REG_EMERG_PAT + CFG_ADDR_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [EVENT_W-1:0] draw_event(int press_pct);
    if ($urandom_range(0, 99) < press_pct) return EVENT_W'($urandom_range(EV_SINGLE, EV_LONG));
    return EV_NONE;
  endfunction

  initial begin : stimulus
    int phase;
    int k;
    int ticks;
    int press_pct;
    int span;
    src_steady  = 1'b0;
    src_run     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_tick(OPENING[i]);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      span = ($urandom_range(0, 3) == 0) ? 40 : 6;
      case (phase)
        // zero periods advance every tick, all lamps dark
        0: program_regs('0, '0, '0, '0, '0);
        1: program_regs('1, '1, '1, '1, '1);
        2: program_regs(1, 1, CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                        CFG_DATA_W'($urandom()));
        default: program_regs(CFG_DATA_W'($urandom_range(1, span)),
                              CFG_DATA_W'($urandom_range(1, span)),
                              CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                              CFG_DATA_W'($urandom()));
      endcase
      press_pct = $urandom_range(5, 50);
      ticks     = (phase == 1) ? FULL_PHASE_TICKS : PHASE_TICKS;
      for (k = 0; k < ticks; k++) begin
        if (k == ticks / 2) drain();
        send_tick(draw_event(press_pct));
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/tlms_pkg.sv
hw/rtl/tlms_cfg_regs.sv
hw/rtl/tlms_core.sv
hw/rtl/traffic_light_mode_sequencer.sv
test/traffic_light_mode_sequencer_tb.sv
